[hdl/bmf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants and types of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_WINDOW  = 15;
   localparam int MAX_HEIGHT  = 2048;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_WINDOW;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int SLOT_W      = $clog2(MAX_WINDOW);
   localparam int ADDR_W      = SLOT_W + COL_W;
   localparam int DIM_W       = 12;
   localparam int WIN_W       = 4;
   localparam int CNT_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int PIX_W       = 8;
   localparam int SUM_W       = 16;
   localparam int KK_W        = 8;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;
   localparam logic [WIN_W-1:0] KMAX = WIN_W'((MAX_WINDOW - 1) | 1);

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_WINDOW_SIZE  = 2'd2
   } reg_index_type;

endpackage
`default_nettype wire

[hdl/bmf_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmf_req_if
// Input channel: pixel and drain beats.
// ----------------------------------------------------------------------------
interface bmf_req_if;
   import bmf_pkg::*;
   logic             valid;
   logic             ready;
   logic             command;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, command, pixel, input ready);
   modport sink (input valid, command, pixel, output ready);
endinterface
`default_nettype wire

[hdl/bmf_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmf_rsp_if
// Result channel: mean beats.
// ----------------------------------------------------------------------------
interface bmf_rsp_if;
   import bmf_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] mean_value;
   logic             frame_last;
   modport source (output valid, mean_value, frame_last, input ready);
   modport sink (input valid, mean_value, frame_last, output ready);
endinterface
`default_nettype wire

[hdl/box_mean_filter_2d.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// box_mean_filter_2d
// Streaming 2-D box mean filter over 8-bit raster frames.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries pixel beats (command 0) in raster order and drain beats
//   (command 1). rsp_bus carries one mean per frame pixel, in raster order,
//   with frame_last on the final one. Results trail the input by p rows and
//   p pixels, p = window_size/2; drain beats release the tail of the frame.
//   The APB port sets frame_width, frame_height and window_size at byte
//   addresses 0, 4 and 8; a write to any of these restarts the frame.
//   For an interior result (k = window side, up to 15), the k*k window
//   pixels come out of the single read port of the line store one per
//   cycle, then the 16-step divider runs.
//   req_bus.ready is high only while the block waits for a beat. A finished
//   result sits in the output register; if the receiver stalls, the next
//   result waits in the block and req_bus.ready stays low meanwhile.
//   Reset clears counters and output valid and loads 640 x 480 with a
//   15 x 15 window; the line store needs no clearing.
// ----------------------------------------------------------------------------
module box_mean_filter_2d (
   input  wire logic                        clock,
   input  wire logic                        reset,
   bmf_req_if.sink                          req_bus,
   bmf_rsp_if.source                        rsp_bus,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [bmf_pkg::PADDR_W-1:0] paddr,
   input  wire logic [bmf_pkg::PDATA_W-1:0] pwdata,
   output logic      [bmf_pkg::PDATA_W-1:0] prdata,
   output logic                             pready
);
   import bmf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_FLUSH, ST_DIV, ST_OUT
   } state_type;

   // configuration
   logic [DIM_W-1:0] width_ff, height_ff;
   logic [WIN_W-1:0] window_ff;
   logic             cfg_wr;
   logic             cfg_hit;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_comb begin
      cfg_hit = 1'b0;
      prdata  = '0;
      unique case (paddr[3:2])
         REG_FRAME_WIDTH: begin
            cfg_hit = 1'b1;
            prdata  = PDATA_W'(width_ff);
         end
         REG_FRAME_HEIGHT: begin
            cfg_hit = 1'b1;
            prdata  = PDATA_W'(height_ff);
         end
         REG_WINDOW_SIZE: begin
            cfg_hit = 1'b1;
            prdata  = PDATA_W'(window_ff);
         end
         default: begin
            cfg_hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         window_ff <= WIN_W'(15);
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_FRAME_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
            REG_WINDOW_SIZE:  window_ff <= pwdata[WIN_W-1:0];
            default:          ;
         endcase
      end
   end

   // effective geometry
   logic [DIM_W-1:0]  w_eff, h_eff, w_m1;
   logic [WIN_W-1:0]  k_eff, k_m1, p_eff;
   logic [KK_W-1:0]   kk;
   logic [CNT_W-1:0]  frame_size;
   logic [CNT_W-1:0]  lag;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
      k_eff = window_ff | WIN_W'(1);
      if (k_eff > KMAX) k_eff = KMAX;
      k_m1       = k_eff - 1'b1;
      p_eff      = k_eff >> 1;
      w_m1       = w_eff - 1'b1;
      kk         = KK_W'(k_eff * k_eff);
      frame_size = CNT_W'(w_eff * h_eff);
      lag        = CNT_W'(p_eff * w_eff) + CNT_W'(p_eff);
   end

   // stream state
   state_type         state_ff;
   logic [CNT_W-1:0]  in_count_ff, out_index_ff;
   logic [COL_W-1:0]  in_col_ff, out_col_ff, col_ptr_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff, row_slot_ff;
   logic [DIM_W-1:0]  out_row_ff;
   logic [WIN_W-1:0]  a_cnt_ff, b_cnt_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic              rd_pend_ff;
   logic              interior_ff, last_ff;
   logic [PIX_W-1:0]  held_mean_ff, div_mean_ff;
   logic              div_start_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [PIX_W-1:0]  rsp_mean_ff;

   logic              accept, all_in, is_pixel, emit, interior;
   logic [SLOT_W-1:0] top_slot;
   logic [COL_W-1:0]  col_start;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [PIX_W-1:0]  rd_data;
   logic              div_done;
   logic [PIX_W-1:0]  div_q;
   logic              out_load;
   logic [PIX_W-1:0]  out_mean;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign all_in        = (in_count_ff == frame_size);
   assign is_pixel      = !req_bus.command && !all_in;

   always_comb begin
      if (is_pixel) begin
         emit = ((in_count_ff + 1'b1) > (out_index_ff + lag)) && (out_index_ff < frame_size);
      end else begin
         emit = all_in && (out_index_ff < frame_size);
      end
      interior = ({1'b0, out_row_ff} >= {1'b0, DIM_W'(p_eff)})
              && (({1'b0, out_row_ff} + (DIM_W + 1)'(p_eff)) < {1'b0, h_eff})
              && ({1'b0, out_col_ff} >= DIM_W'(p_eff))
              && (({1'b0, out_col_ff} + DIM_W'(p_eff)) < w_eff);
      if (out_slot_ff >= SLOT_W'(p_eff)) top_slot = out_slot_ff - SLOT_W'(p_eff);
      else top_slot = out_slot_ff + SLOT_W'(k_eff) - SLOT_W'(p_eff);
      col_start = out_col_ff - COL_W'(p_eff);
      wr_addr   = {in_slot_ff, in_col_ff};
      rd_addr   = {row_slot_ff, col_ptr_ff};
      out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);
      out_mean  = interior_ff ? div_mean_ff : held_mean_ff;
   end

   bmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept && is_pixel),
      .wr_addr (wr_addr[$clog2(STORE_DEPTH)-1:0]),
      .wr_data (req_bus.pixel),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_addr[$clog2(STORE_DEPTH)-1:0]),
      .rd_data (rd_data)
   );

   bmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (acc_ff),
      .divisor  (kk),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_count_ff  <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_index_ff <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_slot_ff  <= '0;
         held_mean_ff <= '0;
         rd_pend_ff   <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         rd_pend_ff   <= (state_ff == ST_READ);
         if (rd_pend_ff) begin
            acc_ff <= acc_ff + SUM_W'(rd_data);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (is_pixel) begin
                     in_count_ff <= in_count_ff + 1'b1;
                     if ({1'b0, in_col_ff} == w_m1) begin
                        in_col_ff  <= '0;
                        in_slot_ff <= (in_slot_ff == SLOT_W'(k_m1)) ? '0 : in_slot_ff + 1'b1;
                     end else begin
                        in_col_ff <= in_col_ff + 1'b1;
                     end
                  end
                  if (emit) begin
                     interior_ff <= interior;
                     last_ff     <= (out_index_ff == frame_size - 1'b1);
                     row_slot_ff <= top_slot;
                     col_ptr_ff  <= col_start;
                     a_cnt_ff    <= '0;
                     b_cnt_ff    <= '0;
                     acc_ff      <= '0;
                     state_ff    <= interior ? ST_READ : ST_OUT;
                  end
               end
            end
            ST_READ: begin
               if (b_cnt_ff == k_m1) begin
                  b_cnt_ff    <= '0;
                  col_ptr_ff  <= col_start;
                  row_slot_ff <= (row_slot_ff == SLOT_W'(k_m1)) ? '0 : row_slot_ff + 1'b1;
                  a_cnt_ff    <= a_cnt_ff + 1'b1;
                  if (a_cnt_ff == k_m1) begin
                     state_ff <= ST_FLUSH;
                  end
               end else begin
                  b_cnt_ff   <= b_cnt_ff + 1'b1;
                  col_ptr_ff <= col_ptr_ff + 1'b1;
               end
            end
            ST_FLUSH: begin
               // last read beat lands in the accumulator this cycle
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  div_mean_ff <= div_q;
                  state_ff    <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_mean_ff  <= out_mean;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= ST_IDLE;
                  if (last_ff) begin
                     in_count_ff  <= '0;
                     in_col_ff    <= '0;
                     in_slot_ff   <= '0;
                     out_index_ff <= '0;
                     out_row_ff   <= '0;
                     out_col_ff   <= '0;
                     out_slot_ff  <= '0;
                     held_mean_ff <= '0;
                  end else begin
                     held_mean_ff <= out_mean;
                     out_index_ff <= out_index_ff + 1'b1;
                     if ({1'b0, out_col_ff} == w_m1) begin
                        out_col_ff  <= '0;
                        out_row_ff  <= out_row_ff + 1'b1;
                        out_slot_ff <= (out_slot_ff == SLOT_W'(k_m1)) ? '0 : out_slot_ff + 1'b1;
                     end else begin
                        out_col_ff <= out_col_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // register writes must only arrive while idle; the block does not enforce this
         if (cfg_wr && cfg_hit) begin
            in_count_ff  <= '0;
            in_col_ff    <= '0;
            in_slot_ff   <= '0;
            out_index_ff <= '0;
            out_row_ff   <= '0;
            out_col_ff   <= '0;
            out_slot_ff  <= '0;
            held_mean_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.mean_value = rsp_mean_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_out_behind_in : assert property (@(posedge clock) disable iff (reset)
      out_index_ff <= in_count_ff)
      else $error("result index ran ahead of input count");

   a_in_bounded : assert property (@(posedge clock) disable iff (reset)
      in_count_ff <= frame_size)
      else $error("input count beyond frame size");

   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff && !cfg_wr) |=> (out_index_ff == '0 && in_count_ff == '0))
      else $error("frame did not restart after last result");

   a_div_in_div : assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");
`endif
endmodule
`default_nettype wire

[hdl/bmf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[hdl/bmf_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmf_div
// Restoring divider, one quotient bit per cycle: window sum by window area.
// ----------------------------------------------------------------------------
module bmf_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [bmf_pkg::SUM_W-1:0] dividend,
   input  wire logic [bmf_pkg::KK_W-1:0]  divisor,
   output logic                           done,
   output logic [bmf_pkg::PIX_W-1:0]      quotient
);
   import bmf_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [KK_W-1:0]   rem_ff;
   logic [SUM_W-1:0]  num_ff;
   logic [KK_W:0]     trial;
   logic [KK_W:0]     diff;
   logic              q_bit;

   always_comb begin
      trial = {rem_ff, num_ff[SUM_W-1]};
      diff  = trial - {1'b0, divisor};
      q_bit = (trial >= {1'b0, divisor});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            num_ff  <= dividend;
         end else if (busy_ff) begin
            // remainder stays below the divisor, so its low bits suffice
            rem_ff  <= q_bit ? diff[KK_W-1:0] : trial[KK_W-1:0];
            num_ff  <= {num_ff[SUM_W-2:0], q_bit};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff[PIX_W-1:0];
endmodule
`default_nettype wire

[bench/box_mean_filter_2d_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// box_mean_filter_2d_tb
// Self-checking bench for the streaming box mean filter. A directed table
// covers extremes, register saturation, small frames and drains. Random frames
// follow, each with random sizes, pixels and drain noise. Every result beat is
// checked against its table entry or a behavioral window-mean predictor.
// ----------------------------------------------------------------------------
module box_mean_filter_2d_tb;
   import bmf_pkg::*;

   localparam int HALF_PERIOD  = 1;
   localparam int RESET_CYCLES = 9;
   localparam int SETTLE       = 300;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int RANDOM_BEATS = 460;
   localparam int SAT_BEATS    = 30;
   localparam int LONG_HOLD    = 2000;
   localparam int REG_SPARE    = 3;
   localparam logic CMD_PIXEL  = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_TYPED, ROW_QUIET} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           sel;    // register index, or the command
      int           val;    // register value, or the pixel
      logic [7:0]   mean;
      logic         last;
   } stim_row_type;

   typedef struct {
      logic [7:0] mean;
      logic       last;
   } mean_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   bmf_req_if req_bus ();
   bmf_rsp_if rsp_bus ();

   box_mean_filter_2d dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state
   logic [7:0] line_rows [0:STORE_DEPTH-1];
   int unsigned width_reg = 640, height_reg = 480, window_reg = 15;
   int unsigned row_in, col_in, next_out;
   logic [7:0] last_mean;
   bit frame_full;

   mean_beat_type pending_means [$];
   int send_idle_pct = 0, recv_idle_pct = 0, hold_left = 0;
   bit hold_trigger = 1'b0, hold_seen = 1'b0;
   int mismatches = 0, beats_sent = 0, means_seen = 0, frames_done = 0;
   longint cycles = 0;

   stim_row_type stim_rows [0:33] = '{
      '{ROW_CFG, REG_FRAME_WIDTH, 1, 0, 0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 1, 0, 0},
      '{ROW_CFG, REG_WINDOW_SIZE, 1, 0, 0},
      '{ROW_TYPED, CMD_PIXEL, 255, 8'd255, 1'b1},
      '{ROW_TYPED, CMD_PIXEL, 0, 8'd0, 1'b1},
      '{ROW_QUIET, CMD_DRAIN, 77, 0, 0},
      '{ROW_CFG, REG_FRAME_WIDTH, 2, 0, 0},
      '{ROW_CFG, REG_WINDOW_SIZE, 15, 0, 0},
      '{ROW_QUIET, CMD_PIXEL, 10, 0, 0},
      '{ROW_QUIET, CMD_PIXEL, 20, 0, 0},
      '{ROW_TYPED, CMD_DRAIN, 0, 8'd0, 1'b0},
      '{ROW_TYPED, CMD_PIXEL, 7, 8'd0, 1'b1},   // extra pixel acts as a drain
      '{ROW_CFG, REG_FRAME_WIDTH, 3, 0, 0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 3, 0, 0},
      '{ROW_CFG, REG_WINDOW_SIZE, 3, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 0, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 255, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 255, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 255, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 255, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 255, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 255, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 255, 0, 0},
      '{ROW_PRED, CMD_PIXEL, 1, 0, 0},
      '{ROW_PRED, CMD_DRAIN, 0, 0, 0},
      '{ROW_PRED, CMD_DRAIN, 0, 0, 0},
      '{ROW_PRED, CMD_DRAIN, 0, 0, 0},
      '{ROW_PRED, CMD_DRAIN, 0, 0, 0},
      '{ROW_CFG, REG_SPARE, 5, 0, 0},
      '{ROW_CFG, REG_WINDOW_SIZE, 2, 0, 0},    // even window rounds up
      '{ROW_CFG, REG_FRAME_WIDTH, 0, 0, 0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 0, 0, 0},
      '{ROW_QUIET, CMD_PIXEL, 128, 0, 0},
      '{ROW_TYPED, CMD_DRAIN, 0, 8'd0, 1'b1}
   };

   function automatic int unsigned eff_width();
      int unsigned w;
      w = width_reg & 12'hFFF;
      return (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = height_reg & 12'hFFF;
      return (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
   endfunction

   function automatic int unsigned eff_window();
      int unsigned k;
      k = (window_reg & 4'hF) | 1;
      return (k > ((MAX_WINDOW - 1) | 1)) ? ((MAX_WINDOW - 1) | 1) : k;
   endfunction

   function automatic void restart_frame();
      row_in = 0;
      col_in = 0;
      next_out = 0;
      last_mean = '0;
      frame_full = 0;
   endfunction

   function automatic mean_beat_type next_mean();
      int unsigned w, h, k, p, r, c, sum;
      mean_beat_type res;
      w = eff_width();
      h = eff_height();
      k = eff_window();
      p = k / 2;
      r = next_out / w;
      c = next_out % w;
      if (r >= p && r + p < h && c >= p && c + p < w) begin
         sum = 0;
         for (int a = 0; a < k; a++)
            for (int b = 0; b < k; b++)
               sum += line_rows[((r - p + a) % k) * MAX_WIDTH + c - p + b];
         last_mean = 8'(sum / (k * k));
      end
      res.mean = last_mean;
      res.last = (next_out == w * h - 1);
      next_out++;
      if (res.last) begin
         restart_frame();
         frames_done++;
      end
      return res;
   endfunction

   // returns 1 when the beat yields a mean
   function automatic bit window_mean_of(input logic cmd, input logic [7:0] pix,
                                         output mean_beat_type res);
      int unsigned w, h, k, lag, count;
      w = eff_width();
      h = eff_height();
      k = eff_window();
      lag = (k / 2) * w + k / 2;
      if (cmd == CMD_DRAIN || frame_full) begin
         if (frame_full && next_out < w * h) begin
            res = next_mean();
            return 1;
         end
         return 0;
      end
      line_rows[(row_in % k) * MAX_WIDTH + col_in] = pix;
      col_in++;
      if (col_in >= w) begin
         col_in = 0;
         row_in++;
      end
      if (row_in >= h) begin
         frame_full = 1;
         count = w * h;
      end else begin
         count = row_in * w + col_in;
      end
      if (count > next_out + lag && next_out < w * h) begin
         res = next_mean();
         return 1;
      end
      return 0;
   endfunction

   // offers one beat; valid is left high after acceptance
   task automatic send_beat(input logic cmd, input logic [7:0] pix, input bit typed,
                            input mean_beat_type typed_res);
      mean_beat_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.pixel <= pix;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      if (window_mean_of(cmd, pix, res))
         pending_means.push_back(typed ? typed_res : res);
      else if (typed)
         pending_means.push_back(typed_res);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
      // a beat with no result may still be busy inside the block
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input int idx, input int unsigned value);
      wait_drained();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= PADDR_W'(idx * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH: width_reg = value & 12'hFFF;
         REG_FRAME_HEIGHT: height_reg = value & 12'hFFF;
         REG_WINDOW_SIZE: window_reg = value & 4'hF;
         default: return;
      endcase
      restart_frame();
   endtask

   // one frame of random pixels, sometimes cut short, with drain noise
   task automatic random_frame();
      int unsigned total, stop_at;
      mean_beat_type none;
      none = '{0, 0};
      total = eff_width() * eff_height();
      stop_at = ($urandom_range(99) < 15) ? $urandom_range(total) : total;
      for (int unsigned i = 0; i < stop_at; i++) begin
         if ($urandom_range(99) < 5) send_beat(CMD_DRAIN, 8'($urandom), 0, none);
         send_beat(CMD_PIXEL, 8'($urandom), 0, none);
      end
      while (frame_full)
         send_beat(($urandom_range(99) < 20) ? CMD_PIXEL : CMD_DRAIN, 8'($urandom), 0, none);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // a toggle of hold_trigger starts a long receiver stall
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      mean_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         means_seen++;
         if (pending_means.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected mean beat: mean %0d last %0b",
                        rsp_bus.mean_value, rsp_bus.frame_last);
         end else begin
            want = pending_means.pop_front();
            if (rsp_bus.mean_value !== want.mean || rsp_bus.frame_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mean beat %0d: expected mean %0d last %0b, got mean %0d last %0b",
                           means_seen, want.mean, want.last,
                           rsp_bus.mean_value, rsp_bus.frame_last);
            end
         end
      end
   end

   initial begin
      mean_beat_type typed_res;
      int unsigned wsize;
      int start_beats;
      bit stalled_once;
      stalled_once = 0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_PIXEL;
      req_bus.pixel = '0;
      for (int i = 0; i < STORE_DEPTH; i++) line_rows[i] = '0;
      restart_frame();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         typed_res = '{stim_rows[i].mean, stim_rows[i].last};
         case (stim_rows[i].kind)
            ROW_CFG: write_reg(stim_rows[i].sel, stim_rows[i].val);
            ROW_TYPED: send_beat(1'(stim_rows[i].sel), 8'(stim_rows[i].val), 1, typed_res);
            default: send_beat(1'(stim_rows[i].sel), 8'(stim_rows[i].val), 0, typed_res);
         endcase
      end

      // largest sizes, saturated registers, part of a frame each
      typed_res = '{0, 0};
      write_reg(REG_FRAME_WIDTH, 12'hFFF);
      write_reg(REG_FRAME_HEIGHT, 1);
      write_reg(REG_WINDOW_SIZE, 3);
      repeat (SAT_BEATS) send_beat(CMD_PIXEL, 8'($urandom), 0, typed_res);
      write_reg(REG_FRAME_WIDTH, 1);
      write_reg(REG_FRAME_HEIGHT, 12'hFFF);
      write_reg(REG_WINDOW_SIZE, 4'hF);
      repeat (SAT_BEATS) send_beat(CMD_PIXEL, 8'($urandom), 0, typed_res);

      start_beats = beats_sent;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 69 : 0;
         recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 32 : 0;
         while (beats_sent < start_beats + (phase + 1) * RANDOM_BEATS / 3) begin
            if (phase == 2 && !stalled_once) begin
               // long receiver stall on a full-size frame while pixels keep coming
               write_reg(REG_FRAME_WIDTH, 12);
               write_reg(REG_FRAME_HEIGHT, 9);
               write_reg(REG_WINDOW_SIZE, 3);
               stalled_once = 1;
               hold_trigger = ~hold_trigger;
            end else begin
               wsize = $urandom_range(99);
               write_reg(REG_FRAME_WIDTH, $urandom_range(1, 12));
               write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 9));
               write_reg(REG_WINDOW_SIZE, (wsize < 10) ? $urandom_range(15) :
                                         (wsize < 60) ? 3 : 2 * $urandom_range(7) + 1);
               if (phase == 2 && hold_left == 0 && $urandom_range(99) < 30)
                  hold_trigger = ~hold_trigger;
            end
            random_frame();
         end
      end

      wait_drained();
      $display("sent %0d beats, checked %0d means over %0d frames", beats_sent,
               means_seen, frames_done);
      $display("frames from 1x1 to 2048 wide, windows 1 to 15, stalls on both sides");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
